// File: src/lpht_pkg.sv
package lpht_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int LEN_W = IDX_W + 1;

	// fixed field widths
	localparam int CFG_W  = 11;
	localparam int KEY_W  = 31;
	localparam int VAL_W  = 32;
	localparam int SLOT_W = 10;
	localparam int ENT_W  = 11;

	// remainder unit: bits retired per cycle
	localparam int MOD_STEPS  = 4;
	localparam int MOD_DIVD_W = ((KEY_W + MOD_STEPS - 1) / MOD_STEPS) * MOD_STEPS;
	localparam int MOD_ITERS  = MOD_DIVD_W / MOD_STEPS;
	localparam int MOD_CNT_W  = (MOD_ITERS > 1) ? $clog2(MOD_ITERS) : 1;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_COUNT  = 2'd1,
		REQ_FIND   = 2'd2,
		REQ_REMOVE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_PRESENT = 2'd1,
		STAT_MISSING = 2'd2,
		STAT_FULL    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MARK_EMPTY = 2'd0,
		MARK_LIVE  = 2'd1,
		MARK_TOMB  = 2'd2,
		MARK_RSVD  = 2'd3
	} mark_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_PROBE,
		S_EXEC
	} state_t;

	typedef struct packed {
		mark_t            mark;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} slot_word_t;

	localparam int WORD_W = $bits(slot_word_t);

	// table_len 0 acts as 1, anything above the depth as the depth
	function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] cfg_len);
		logic [LEN_W-1:0] r;
		if (cfg_len == '0) begin
			r = LEN_W'(1);
		end else if (32'(cfg_len) > TABLE_DEPTH) begin
			r = LEN_W'(TABLE_DEPTH);
		end else begin
			r = LEN_W'(cfg_len);
		end
		return r;
	endfunction

endpackage

// File: src/lpht_if.sv
interface lpht_req_if;
	import lpht_pkg::*;
	logic             valid;
	logic             ready;
	logic [1:0]       req_type;
	logic [KEY_W-1:0] key;
	logic [VAL_W-1:0] value_in;
	modport source (output valid, req_type, key, value_in, input ready);
	modport sink (input valid, req_type, key, value_in, output ready);
endinterface

interface lpht_rsp_if;
	import lpht_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [VAL_W-1:0]  value_out;
	logic [SLOT_W-1:0] slot;
	logic [ENT_W-1:0]  entry_total;
	logic              is_empty;
	modport source (output valid, status, value_out, slot, entry_total, is_empty, input ready);
	modport sink (input valid, status, value_out, slot, entry_total, is_empty, output ready);
endinterface

interface lpht_cfg_if;
	import lpht_pkg::*;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] table_len;
	modport source (output valid, table_len, input ready);
	modport sink (input valid, table_len, output ready);
endinterface

// File: src/linear_probe_hash_table.sv
// Flow per request: the remainder unit (4 key bits per cycle) computes the home slot,
//   which is loaded as the first read address; after the registered RAM read, one slot is
//   checked per cycle until a hit, an empty slot or a full pass, then one read-modify-write.
// One request at a time; a waiting result does not block acceptance, but the next write-back waits for it.
// Reset: marks are swept to empty across all TABLE_DEPTH (1024) slots, no request taken meanwhile;
//   configuration writes are taken at any time. table_len resets to 1024.
module linear_probe_hash_table (
	input  logic        clk,
	input  logic        arst_n,
	lpht_cfg_if.sink    cfg,
	lpht_req_if.sink    req,
	lpht_rsp_if.source  rsp
);
	import lpht_pkg::*;

	state_t state_q, state_n;

	logic [CFG_W-1:0] table_len_q;
	logic [LEN_W-1:0] live_q;
	logic [IDX_W-1:0] clr_idx_q;

	req_t             req_type_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] vin_q;
	logic [LEN_W-1:0] len_q;

	logic [IDX_W-1:0] iss_pos_q;
	logic [LEN_W-1:0] iss_cnt_q;
	logic [LEN_W-1:0] chk_cnt_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_pos_s1;

	logic             found_q;
	logic [IDX_W-1:0] hit_q;
	logic [VAL_W-1:0] hit_val_q;
	logic             have_free_q;
	logic [IDX_W-1:0] free_q;

	logic              rsp_vld_q;
	status_t           rsp_status_q;
	logic [VAL_W-1:0]  rsp_value_q;
	logic [SLOT_W-1:0] rsp_slot_q;
	logic [ENT_W-1:0]  rsp_total_q;
	logic              rsp_empty_q;

	// FSM outputs
	logic req_acc;
	logic iss_en;
	logic clr_we;
	logic exec_go;

	// remainder unit
	logic             mod_done;
	logic [IDX_W-1:0] mod_rem;

	// RAM
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	slot_word_t        ram_wword;
	logic [WORD_W-1:0] ram_rdata;
	slot_word_t        rd_word;

	// probe check
	logic hit_now, empty_now, last_now, free_now, term;

	// read-modify-write
	logic             x_we;
	logic [IDX_W-1:0] x_addr;
	slot_word_t       x_word;
	status_t          x_status;
	logic [VAL_W-1:0] x_value;
	logic [IDX_W-1:0] x_slot;
	logic [LEN_W-1:0] x_live;

	lpht_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req_acc),
		.dividend (req.key),
		.divisor  (eff_len(table_len_q)),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	lpht_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (WORD_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wword),
		.re    (iss_en),
		.raddr (iss_pos_q),
		.rdata (ram_rdata)
	);

	assign rd_word = slot_word_t'(ram_rdata);

	always_comb begin
		hit_now   = rd_vld_s1 && (rd_word.mark == MARK_LIVE) && (rd_word.key == key_q);
		empty_now = rd_vld_s1 && (rd_word.mark == MARK_EMPTY);
		free_now  = rd_vld_s1 && !have_free_q && (rd_word.mark != MARK_LIVE);
		last_now  = rd_vld_s1 && ((chk_cnt_q + 1'b1) == len_q);
		term      = hit_now || empty_now || last_now;
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_idx_q == IDX_W'(TABLE_DEPTH - 1)) state_n = S_IDLE;
			S_IDLE:  if (req.valid) state_n = S_DIV;
			S_DIV:   if (mod_done) state_n = S_PROBE;
			S_PROBE: if (term) state_n = S_EXEC;
			S_EXEC:  if (!rsp_vld_q || rsp.ready) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		req_acc = 1'b0;
		iss_en  = 1'b0;
		clr_we  = 1'b0;
		exec_go = 1'b0;
		unique case (state_q)
			S_CLEAR: clr_we = 1'b1;
			S_IDLE:  req_acc = req.valid;
			S_DIV:   ;
			S_PROBE: iss_en = (iss_cnt_q != len_q);
			S_EXEC:  exec_go = !rsp_vld_q || rsp.ready;
			default: ;
		endcase
	end

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// result and write-back from the probe outcome
	always_comb begin
		x_we     = 1'b0;
		x_addr   = hit_q;
		x_word   = '{mark: MARK_LIVE, key: key_q, value: hit_val_q};
		x_status = STAT_DONE;
		x_value  = '0;
		x_slot   = '0;
		x_live   = live_q;
		unique case (req_type_q)
			REQ_INSERT, REQ_COUNT: begin
				if (found_q) begin
					x_slot = hit_q;
					if (req_type_q == REQ_INSERT) begin
						x_status = STAT_PRESENT;
						x_value  = hit_val_q;
					end else begin
						x_we         = 1'b1;
						x_word.value = hit_val_q + 1'b1;
						x_value      = hit_val_q + 1'b1;
					end
				end else if (have_free_q) begin
					x_we         = 1'b1;
					x_addr       = free_q;
					x_word.value = (req_type_q == REQ_INSERT) ? vin_q : VAL_W'(1);
					x_value      = x_word.value;
					x_slot       = free_q;
					x_live       = live_q + 1'b1;
				end else begin
					x_status = STAT_FULL;
				end
			end
			REQ_FIND: begin
				if (found_q) begin
					x_value = hit_val_q;
					x_slot  = hit_q;
				end else begin
					x_status = STAT_MISSING;
				end
			end
			REQ_REMOVE: begin
				if (found_q) begin
					x_we        = 1'b1;
					x_word.mark = MARK_TOMB;
					x_slot      = hit_q;
					if (live_q != '0) x_live = live_q - 1'b1;
				end else begin
					x_status = STAT_MISSING;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		ram_we    = clr_we || (exec_go && x_we);
		ram_waddr = clr_we ? clr_idx_q : x_addr;
		ram_wword = x_word;
		if (clr_we) begin
			ram_wword.mark = MARK_EMPTY;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			table_len_q <= CFG_W'(TABLE_DEPTH);
			live_q      <= '0;
			clr_idx_q   <= '0;
			rsp_vld_q   <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg.valid) begin
				table_len_q <= cfg.table_len;
			end
			if (clr_we) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (state_q == S_DIV) begin
				rd_vld_s1 <= 1'b0;
			end else begin
				rd_vld_s1 <= iss_en;
			end
			if (exec_go) begin
				live_q    <= x_live;
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_type_q <= req_t'(req.req_type);
			key_q      <= req.key;
			vin_q      <= req.value_in;
			len_q      <= eff_len(table_len_q);
		end
		if (state_q == S_DIV && mod_done) begin
			iss_pos_q   <= mod_rem;
			iss_cnt_q   <= '0;
			chk_cnt_q   <= '0;
			found_q     <= 1'b0;
			have_free_q <= 1'b0;
		end
		if (iss_en) begin
			rd_pos_s1 <= iss_pos_q;
			iss_cnt_q <= iss_cnt_q + 1'b1;
			// wrap at the configured length
			if ({1'b0, iss_pos_q} == len_q - 1'b1) begin
				iss_pos_q <= '0;
			end else begin
				iss_pos_q <= iss_pos_q + 1'b1;
			end
		end
		if (state_q == S_PROBE && rd_vld_s1) begin
			chk_cnt_q <= chk_cnt_q + 1'b1;
			if (free_now) begin
				have_free_q <= 1'b1;
				free_q      <= rd_pos_s1;
			end
			if (hit_now) begin
				found_q   <= 1'b1;
				hit_q     <= rd_pos_s1;
				hit_val_q <= rd_word.value;
			end
		end
		if (exec_go) begin
			rsp_status_q <= x_status;
			rsp_value_q  <= x_value;
			rsp_slot_q   <= SLOT_W'(x_slot);
			rsp_total_q  <= ENT_W'(x_live);
			rsp_empty_q  <= (x_live == '0);
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.value_out   = rsp_value_q;
	assign rsp.slot        = rsp_slot_q;
	assign rsp.entry_total = rsp_total_q;
	assign rsp.is_empty    = rsp_empty_q;

	a_chk_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE && rd_vld_s1) |-> (chk_cnt_q < len_q))
		else $error("probe checks past one full pass");

	a_pos_in_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE) |-> ({1'b0, iss_pos_q} < len_q))
		else $error("probe position beyond table length");

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(live_q) <= TABLE_DEPTH)
		else $error("live count above table depth");

	a_acc_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> (state_q == S_DIV))
		else $error("accepted request did not start the remainder");

	a_no_wr_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE || state_q == S_DIV) |-> !ram_we)
		else $error("slot write while a probe is in flight");

endmodule

// File: src/lpht_ram.sv
module lpht_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 65
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/lpht_mod.sv
// key % len, restoring remainder, MOD_STEPS dividend bits per cycle
module lpht_mod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [lpht_pkg::KEY_W-1:0] dividend,
	input  logic [lpht_pkg::LEN_W-1:0] divisor,
	output logic                      done,
	output logic [lpht_pkg::IDX_W-1:0] rem
);
	import lpht_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [MOD_CNT_W-1:0]  cnt_q;
	logic [MOD_DIVD_W-1:0] divd_q;
	logic [LEN_W-1:0]      rem_q;
	logic [LEN_W-1:0]      dvs_q;

	logic [MOD_DIVD_W-1:0] divd_n;
	logic [LEN_W-1:0]      rem_n;
	logic [LEN_W:0]        trial;

	always_comb begin
		divd_n = divd_q;
		rem_n  = rem_q;
		trial  = '0;
		for (int i = 0; i < MOD_STEPS; i++) begin
			trial  = {rem_n, divd_n[MOD_DIVD_W-1]};
			divd_n = {divd_n[MOD_DIVD_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				trial = trial - {1'b0, dvs_q};
			end
			rem_n = trial[LEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MOD_CNT_W'(MOD_ITERS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			divd_q <= MOD_DIVD_W'(dividend);
			dvs_q  <= divisor;
			rem_q  <= '0;
		end else if (busy_q) begin
			divd_q <= divd_n;
			rem_q  <= rem_n;
		end
	end

	assign done = done_q;
	assign rem  = rem_q[IDX_W-1:0];

endmodule

// File: dv/tb.sv
module tb;
	import lpht_pkg::*;

	typedef struct {
		req_t             op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} table_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [VAL_W-1:0]  value_out;
		logic [SLOT_W-1:0] slot;
		logic [ENT_W-1:0]  entry_total;
		logic              is_empty;
	} table_result_t;

	localparam int IDLE_NONE   = 0;
	localparam int IDLE_SENDER = 1;
	localparam int IDLE_RECV   = 2;
	localparam int IDLE_BOTH   = 3;

	logic clk;
	logic arst_n;

	lpht_req_if req_bus();
	lpht_rsp_if rsp_bus();
	lpht_cfg_if cfg_bus();

	linear_probe_hash_table u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// predictor copy of the table
	mark_t            slot_state [TABLE_DEPTH];
	logic [KEY_W-1:0] slot_keys  [TABLE_DEPTH];
	logic [VAL_W-1:0] slot_vals  [TABLE_DEPTH];
	int unsigned      live_entries;
	logic [CFG_W-1:0] tbl_len_cfg;

	table_req_t    pending_reqs [$];
	table_result_t expected_results [$];
	logic [KEY_W-1:0] key_pool [128];

	int  idle_mode;
	int  hold_req;
	bit  req_taken;
	int  errors;
	int  reqs_sent;
	int  results_seen;
	int  cfg_writes;
	int  status_seen [4];
	longint cycle_count;
	longint cycle_budget;

	function automatic int unsigned active_len();
		if (tbl_len_cfg == '0) return 1;
		if (int'(tbl_len_cfg) > TABLE_DEPTH) return TABLE_DEPTH;
		return int'(tbl_len_cfg);
	endfunction

	function automatic table_result_t predict_table_op(req_t op, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
		int unsigned len;
		int unsigned pos;
		int unsigned hit;
		int unsigned free_slot;
		bit found;
		bit have_free;
		table_result_t r;
		len = active_len();
		pos = k % len;
		found = 0;
		have_free = 0;
		hit = 0;
		free_slot = 0;
		r = '0;
		r.status = STAT_DONE;
		// probe stops at a matching live key, a never-used slot or after one full lap
		for (int n = 0; n < len; n++) begin
			if (slot_state[pos] == MARK_EMPTY) begin
				if (!have_free) begin
					have_free = 1;
					free_slot = pos;
				end
				break;
			end
			if (slot_state[pos] == MARK_LIVE) begin
				if (slot_keys[pos] == k) begin
					found = 1;
					hit = pos;
					break;
				end
			end else if (!have_free) begin
				have_free = 1;
				free_slot = pos;
			end
			pos++;
			if (pos >= len) pos = 0;
		end
		case (op)
			REQ_INSERT, REQ_COUNT: begin
				if (found) begin
					if (op == REQ_INSERT) begin
						r.status = STAT_PRESENT;
					end else begin
						slot_vals[hit] = slot_vals[hit] + 32'd1;
					end
					r.value_out = slot_vals[hit];
					r.slot = SLOT_W'(hit);
				end else if (have_free) begin
					slot_state[free_slot] = MARK_LIVE;
					slot_keys[free_slot] = k;
					slot_vals[free_slot] = (op == REQ_INSERT) ? v : 32'd1;
					live_entries++;
					r.value_out = slot_vals[free_slot];
					r.slot = SLOT_W'(free_slot);
				end else begin
					r.status = STAT_FULL;
				end
			end
			REQ_FIND: begin
				if (found) begin
					r.value_out = slot_vals[hit];
					r.slot = SLOT_W'(hit);
				end else begin
					r.status = STAT_MISSING;
				end
			end
			default: begin
				if (found) begin
					slot_state[hit] = MARK_TOMB;
					if (live_entries > 0) live_entries--;
					r.slot = SLOT_W'(hit);
				end else begin
					r.status = STAT_MISSING;
				end
			end
		endcase
		r.entry_total = ENT_W'(live_entries);
		r.is_empty = (live_entries == 0);
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > cycle_budget) begin
			$display("%0t: watchdog expired after %0d cycles, %0d results outstanding",
				$time, cycle_count, expected_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// request driver: valid holds until the request is taken
	always @(negedge clk) begin : drive_req
		table_req_t item;
		int roll;
		if (arst_n && (!req_bus.valid || req_taken)) begin
			req_taken = 0;
			roll = $urandom_range(0, 99);
			if (pending_reqs.size() != 0 &&
					!((idle_mode == IDLE_SENDER && roll < 60) ||
					(idle_mode == IDLE_BOTH && roll < 25))) begin
				item = pending_reqs.pop_front();
				req_bus.req_type <= item.op;
				req_bus.key      <= item.key;
				req_bus.value_in <= item.value;
				req_bus.valid    <= 1'b1;
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : drive_ready
		int roll;
		int hold_left;
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		roll = $urandom_range(0, 99);
		if (hold_left > 0) begin
			hold_left--;
			rsp_bus.ready <= 1'b0;
		end else if ((idle_mode == IDLE_RECV && roll < 60) ||
				(idle_mode == IDLE_BOTH && roll < 25)) begin
			rsp_bus.ready <= 1'b0;
		end else begin
			rsp_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : watch
		table_result_t got;
		table_result_t want;
		if (arst_n) begin
			// results first: a result never belongs to a request taken at the same edge
			if (rsp_bus.valid && rsp_bus.ready) begin
				got.status      = rsp_bus.status;
				got.value_out   = rsp_bus.value_out;
				got.slot        = rsp_bus.slot;
				got.entry_total = rsp_bus.entry_total;
				got.is_empty    = rsp_bus.is_empty;
				results_seen++;
				status_seen[got.status]++;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result st=%0d val=%h slot=%0d ent=%0d empty=%0b",
						$time, got.status, got.value_out, got.slot, got.entry_total,
						got.is_empty);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: mismatch expected st=%0d val=%h slot=%0d ent=%0d empty=%0b",
							$time, want.status, want.value_out, want.slot, want.entry_total,
							want.is_empty);
						$display("%0t:          actual   st=%0d val=%h slot=%0d ent=%0d empty=%0b",
							$time, got.status, got.value_out, got.slot, got.entry_total,
							got.is_empty);
					end
				end
			end
			if (req_bus.valid && req_bus.ready) begin
				expected_results.push_back(predict_table_op(req_t'(req_bus.req_type),
					req_bus.key, req_bus.value_in));
				req_taken = 1;
				reqs_sent++;
			end
		end
	end

	task automatic push_req(input req_t op, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		table_req_t item;
		item.op = op;
		item.key = k;
		item.value = v;
		pending_reqs.push_back(item);
		cycle_budget += 200 + 4 * active_len();
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_reqs.size() != 0 || req_bus.valid || expected_results.size() != 0);
	endtask

	task automatic write_table_len(input logic [CFG_W-1:0] len_val);
		@(negedge clk);
		cfg_bus.table_len <= len_val;
		cfg_bus.valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_bus.ready);
		tbl_len_cfg = len_val;
		cfg_writes++;
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] len_val, input int mode,
			input int n_items, input int pool_n, input int holdoff);
		int unsigned len;
		int roll;
		req_t op;
		logic [KEY_W-1:0] k;
		logic [VAL_W-1:0] v;
		wait_drained();
		write_table_len(len_val);
		idle_mode = mode;
		len = active_len();
		// half the pool clusters on a few home slots, half spans the key range
		for (int i = 0; i < pool_n; i++) begin
			if (i % 2 != 0)
				key_pool[i] = KEY_W'($urandom);
			else
				key_pool[i] = KEY_W'($urandom_range(0, 2000000) * len + $urandom_range(0, 3));
		end
		cycle_budget += 1000 + holdoff;
		if (holdoff != 0) hold_req = holdoff;
		for (int i = 0; i < n_items; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 30) op = REQ_INSERT;
			else if (roll < 55) op = REQ_COUNT;
			else if (roll < 80) op = REQ_FIND;
			else op = REQ_REMOVE;
			if ($urandom_range(0, 99) < 85)
				k = key_pool[$urandom_range(0, pool_n - 1)];
			else
				k = KEY_W'($urandom);
			case ($urandom_range(0, 19))
				0: v = 32'h8000_0000;
				1: v = 32'h7fff_ffff;
				2: v = 32'hffff_ffff;
				3: v = 32'h0;
				default: v = $urandom;
			endcase
			push_req(op, k, v);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.req_type = REQ_INSERT;
		req_bus.key = '0;
		req_bus.value_in = '0;
		rsp_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.table_len = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			slot_state[i] = MARK_EMPTY;
			slot_keys[i] = '0;
			slot_vals[i] = '0;
		end
		live_entries = 0;
		tbl_len_cfg = CFG_W'(1024);
		idle_mode = IDLE_NONE;
		hold_req = 0;
		req_taken = 0;
		errors = 0;
		reqs_sent = 0;
		results_seen = 0;
		cfg_writes = 0;
		status_seen = '{default: 0};
		cycle_count = 0;
		// clearing sweep after reset plus margin
		cycle_budget = 8000;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed requests at the reset length
		push_req(REQ_FIND,   31'd0, 32'h0);
		push_req(REQ_REMOVE, 31'd0, 32'h0);
		push_req(REQ_INSERT, 31'd0, 32'h8000_0000);
		push_req(REQ_INSERT, 31'd0, 32'h1234_5678);
		push_req(REQ_INSERT, 31'h7fff_ffff, 32'h7fff_ffff);
		// same home slot as the max key: wraps past slot 0
		push_req(REQ_INSERT, 31'd2047, 32'hffff_ffff);
		push_req(REQ_FIND,   31'd2047, 32'h0);
		push_req(REQ_COUNT,  31'd5, 32'h0);
		push_req(REQ_COUNT,  31'd5, 32'h0);
		push_req(REQ_INSERT, 31'd7, 32'hffff_ffff);
		push_req(REQ_COUNT,  31'd7, 32'h0);
		push_req(REQ_INSERT, 31'd9, 32'h7fff_ffff);
		push_req(REQ_COUNT,  31'd9, 32'h0);
		push_req(REQ_REMOVE, 31'h7fff_ffff, 32'h0);
		// chain through the tombstone still reaches slot 1
		push_req(REQ_FIND,   31'd2047, 32'h0);
		push_req(REQ_INSERT, 31'd3071, 32'h5555_aaaa);
		push_req(REQ_REMOVE, 31'd3071, 32'h0);
		push_req(REQ_REMOVE, 31'd2047, 32'h0);
		push_req(REQ_REMOVE, 31'd0, 32'h0);
		push_req(REQ_REMOVE, 31'd5, 32'h0);
		push_req(REQ_REMOVE, 31'd7, 32'h0);
		push_req(REQ_REMOVE, 31'd9, 32'h0);
		push_req(REQ_FIND,   31'd3071, 32'h0);
		push_req(REQ_REMOVE, 31'd3071, 32'h0);

		run_phase(CFG_W'(1),    IDLE_NONE,   60,  4,   0);
		run_phase(CFG_W'(0),    IDLE_SENDER, 60,  4,   0);
		run_phase(CFG_W'(7),    IDLE_RECV,   250, 12,  400);
		run_phase(CFG_W'(16),   IDLE_BOTH,   250, 24,  0);
		run_phase(CFG_W'(61),   IDLE_NONE,   250, 80,  0);
		run_phase(CFG_W'(2047), IDLE_SENDER, 200, 96,  0);
		run_phase(CFG_W'(200),  IDLE_RECV,   250, 128, 0);
		run_phase(CFG_W'(3),    IDLE_BOTH,   200, 6,   0);
		run_phase(CFG_W'(33),   IDLE_SENDER, 200, 40,  0);
		run_phase(CFG_W'(1024), IDLE_NONE,   150, 64,  0);

		wait_drained();
		cycle_budget += 200;
		repeat (64) @(posedge clk);
		if (expected_results.size() != 0) begin
			errors++;
			$display("%0t: %0d expected results never arrived", $time, expected_results.size());
		end
		$display("Ran %0d requests and %0d results over %0d table length settings.",
			reqs_sent, results_seen, cfg_writes);
		$display("Statuses seen: done %0d, present %0d, missing %0d, full %0d.",
			status_seen[STAT_DONE], status_seen[STAT_PRESENT], status_seen[STAT_MISSING],
			status_seen[STAT_FULL]);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/lpht_pkg.sv
src/lpht_if.sv
src/lpht_ram.sv
src/lpht_mod.sv
src/linear_probe_hash_table.sv
dv/tb.sv
